// ===== design/lle_pkg.sv =====
package lle_pkg;

    localparam int unsigned CAPACITY_DEF = 64;

    typedef enum logic [3:0] {
        REQ_INS_FRONT  = 4'd0,
        REQ_INS_BACK   = 4'd1,
        REQ_INS_AFTER  = 4'd2,
        REQ_INS_BEFORE = 4'd3,
        REQ_DEL_FRONT  = 4'd4,
        REQ_DEL_BACK   = 4'd5,
        REQ_DEL_VALUE  = 4'd6,
        REQ_FIND       = 4'd7,
        REQ_PEEK_FRONT = 4'd8,
        REQ_PEEK_BACK  = 4'd9,
        REQ_POP_FRONT  = 4'd10,
        REQ_POP_BACK   = 4'd11
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_END,
        S_FREE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_NB_RD,
        S_NB_WAIT,
        S_LINK0,
        S_LINK1,
        S_LINK2,
        S_LINK3,
        S_DONE
    } t_state;

endpackage

// ===== design/lle_free_scan.sv =====
module lle_free_scan #(
    parameter int unsigned CAPACITY = lle_pkg::CAPACITY_DEF,
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_release,
    input  logic [AW-1:0] i_release_slot,
    output logic          o_done,
    output logic [AW-1:0] o_slot
);
    import lle_pkg::*;

    // one slot examined per cycle; the claimed slot is marked used at o_done
    logic [CAPACITY-1:0] r_free;
    logic [AW-1:0]       r_idx, n_idx;
    logic                r_busy, n_busy;
    logic                hit;

    assign hit    = r_busy && r_free[r_idx];
    assign o_done = hit;
    assign o_slot = r_idx;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (hit) begin
            n_busy = 1'b0;
        end else if (r_busy) begin
            n_idx = r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            if (hit)
                r_free[r_idx] <= 1'b0;
            if (i_release)
                r_free[i_release_slot] <= 1'b1;
        end
    end
endmodule

// ===== design/linked_list_engine.sv =====
// a request runs through the states from decode to done; unused codes and full or
// empty answers go straight from decode to done, peek reads the end entry, delete or pop
// also unlinks it, front or back insert first scans for the lowest free slot; key searches
// walk the entries from the head one at a time, and insert after or before scans after a hit
// one request in flight: the next is taken the cycle after the result transfer
// synchronous active-low reset empties the list and frees every slot; memories keep data
module linked_list_engine #(
    parameter int unsigned CAPACITY = lle_pkg::CAPACITY_DEF,
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [3:0]            i_req_type,
    input  logic signed [31:0]    i_key,
    input  logic signed [31:0]    i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_status,
    output logic                  o_found,
    output logic signed [31:0]    o_read_data,
    output logic [CW-1:0]         o_entry_count,
    output logic                  o_empty_res
);
    import lle_pkg::*;

    logic signed [31:0] r_vals [CAPACITY];
    logic [AW-1:0]      r_nxt  [CAPACITY];
    logic [AW-1:0]      r_prv  [CAPACITY];

    t_state r_state, n_state;
    logic [3:0]         r_req;
    logic signed [31:0] r_key, r_val;
    logic [AW-1:0]      r_head, r_tail, r_cur, r_m, r_a, r_b;
    logic [CW-1:0]      r_cnt, r_walk;
    logic signed [31:0] r_rd_v;
    logic [AW-1:0]      r_rd_n, r_rd_p;
    logic [1:0]         r_status;
    logic               r_found, r_ovalid;
    logic signed [31:0] r_rdata;

    logic          fs_start, fs_done, rel;
    logic [AW-1:0] fs_slot;
    logic          is_ins, is_search, is_front, is_take, cmp_eq;

    lle_free_scan #(.CAPACITY(CAPACITY)) u_free (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(fs_start),
        .i_release(rel), .i_release_slot(r_cur),
        .o_done(fs_done), .o_slot(fs_slot)
    );

    assign o_ready       = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_read_data   = r_rdata;
    assign o_entry_count = r_cnt;
    assign o_empty_res   = (r_cnt == '0);

    assign is_ins    = (r_req <= 4'(REQ_INS_BEFORE));
    assign is_search = (r_req == 4'(REQ_INS_AFTER)) || (r_req == 4'(REQ_INS_BEFORE)) ||
                       (r_req == 4'(REQ_DEL_VALUE)) || (r_req == 4'(REQ_FIND));
    assign is_front  = (r_req == 4'(REQ_DEL_FRONT)) || (r_req == 4'(REQ_PEEK_FRONT)) ||
                       (r_req == 4'(REQ_POP_FRONT));
    assign is_take   = (r_req == 4'(REQ_DEL_FRONT)) || (r_req == 4'(REQ_DEL_BACK)) ||
                       (r_req == 4'(REQ_POP_FRONT)) || (r_req == 4'(REQ_POP_BACK)) ||
                       (r_req == 4'(REQ_DEL_VALUE));
    assign cmp_eq    = (r_rd_v == r_key);
    // the scan starts on the way into S_FREE, from decode or from a search hit
    assign fs_start  = ((r_state == S_DECODE) && is_ins && (r_cnt != CW'(CAPACITY)) &&
                        !is_search) ||
                       ((r_state == S_SRCH_CMP) && is_ins && cmp_eq);
    // freed slot goes back to the map as the unlink completes
    assign rel       = (r_state == S_LINK3) && !is_ins;

    // next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_valid && o_ready) n_state = S_DECODE;
            S_DECODE: begin
                if (r_req > 4'(REQ_POP_BACK))
                    n_state = S_DONE;
                else if (is_ins && r_cnt == CW'(CAPACITY))
                    n_state = S_DONE;
                else if (is_search)
                    n_state = (r_cnt == '0) ? S_DONE : S_SRCH_RD;
                else if (is_ins)
                    n_state = S_FREE;
                else
                    n_state = (r_cnt == '0) ? S_DONE : S_RD_END;
            end
            S_SRCH_RD:  n_state = S_SRCH_CMP;
            S_SRCH_CMP: begin
                if (cmp_eq)
                    n_state = (r_req == 4'(REQ_FIND)) ? S_DONE :
                              (r_req == 4'(REQ_DEL_VALUE)) ? S_NB_RD : S_FREE;
                else if (r_walk == CW'(1))
                    n_state = S_DONE;
                else
                    n_state = S_SRCH_RD;
            end
            S_RD_END:   n_state = S_NB_WAIT;
            S_NB_WAIT:  n_state = is_take ? S_NB_RD : S_DONE;
            S_NB_RD:    n_state = S_LINK0;
            S_FREE:     if (fs_done) n_state = S_LINK0;
            S_LINK0:    n_state = S_LINK1;
            S_LINK1:    n_state = S_LINK2;
            S_LINK2:    n_state = S_LINK3;
            S_LINK3:    n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // one read port into the slot memories, registered
    logic [AW-1:0] rd_addr;
    always_comb begin
        rd_addr = r_cur;
    end

    always_ff @(posedge i_clk) begin
        r_rd_v <= r_vals[rd_addr];
        r_rd_n <= r_nxt[rd_addr];
        r_rd_p <= r_prv[rd_addr];
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready)
                r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req    <= i_req_type;
                        r_key    <= i_key;
                        r_val    <= i_value;
                        r_status <= ST_OK;
                        r_found  <= 1'b0;
                        r_rdata  <= '0;
                    end
                end
                S_DECODE: begin
                    r_walk <= r_cnt;
                    r_cur  <= (is_front || is_search) ? r_head : r_tail;
                    if (is_ins && r_cnt == CW'(CAPACITY))
                        r_status <= ST_FULL;
                    else if (is_search && r_cnt == '0)
                        r_status <= ST_NOT_FOUND;
                    else if (!is_ins && !is_search && r_req <= 4'(REQ_POP_BACK) &&
                             r_cnt == '0)
                        r_status <= ST_EMPTY;
                end
                S_SRCH_CMP: begin
                    if (cmp_eq) begin
                        if (r_req == 4'(REQ_FIND)) r_found <= 1'b1;
                        r_a <= r_rd_p;
                        r_b <= r_rd_n;
                    end else begin
                        r_walk <= r_walk - CW'(1);
                        r_cur  <= r_rd_n;
                        if (r_walk == CW'(1)) r_status <= ST_NOT_FOUND;
                    end
                end
                S_NB_WAIT: begin
                    if (r_req >= 4'(REQ_PEEK_FRONT)) r_rdata <= r_rd_v;
                end
                S_NB_RD: begin
                    r_a <= r_rd_p;
                    r_b <= r_rd_n;
                end
                S_FREE: begin
                    if (fs_done) r_m <= fs_slot;
                end
                S_LINK0: begin
                    if (is_ins) begin
                        r_vals[r_m] <= r_val;
                        if (r_cnt == '0) begin
                            r_nxt[r_m] <= r_m;
                            r_prv[r_m] <= r_m;
                            r_head <= r_m;
                            r_tail <= r_m;
                        end else if (r_req == 4'(REQ_INS_AFTER)) begin
                            r_a <= r_cur;
                        end else if (r_req == 4'(REQ_INS_BEFORE)) begin
                            r_b <= r_cur;
                        end else begin
                            r_a <= r_tail;
                            r_b <= r_head;
                        end
                    end else if (r_cnt != CW'(1)) begin
                        r_nxt[r_a] <= r_b;
                        if (r_cur == r_head) r_head <= r_b;
                        if (r_cur == r_tail) r_tail <= r_a;
                    end
                end
                S_LINK1: begin
                    if (is_ins && r_cnt != '0) begin
                        r_nxt[r_m] <= r_b;
                        r_prv[r_m] <= r_a;
                    end else if (!is_ins && r_cnt != CW'(1)) begin
                        r_prv[r_b] <= r_a;
                    end
                end
                S_LINK2: begin
                    if (is_ins && r_cnt != '0) begin
                        r_nxt[r_a] <= r_m;
                        case (r_req)
                            4'(REQ_INS_FRONT):  r_head <= r_m;
                            4'(REQ_INS_BACK):   r_tail <= r_m;
                            4'(REQ_INS_AFTER):  if (r_cur == r_tail) r_tail <= r_m;
                            4'(REQ_INS_BEFORE): if (r_cur == r_head) r_head <= r_m;
                            default: ;
                        endcase
                    end
                end
                S_LINK3: begin
                    if (is_ins) begin
                        if (r_cnt != '0) r_prv[r_b] <= r_m;
                        r_cnt <= r_cnt + CW'(1);
                    end else begin
                        if (r_cnt == CW'(1)) begin
                            r_head <= '0;
                            r_tail <= '0;
                        end
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import lle_pkg::*;

    localparam int CAP = 64;
    localparam int LIMIT_CYCLES = 900000;
    localparam int N_RANDOM = 450;
    localparam logic [3:0] REQ_UNUSED = 4'd13;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [3:0] i_req_type = '0;
    logic signed [31:0] i_key = '0;
    logic signed [31:0] i_value = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [1:0] o_status;
    logic o_found;
    logic signed [31:0] o_read_data;
    logic [6:0] o_entry_count;
    logic o_empty_res;

    linked_list_engine uut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [1:0] status;
        logic found;
        logic signed [31:0] read_data;
        logic [6:0] entry_count;
        logic empty_res;
    } t_resp;

    // list contents in order, front at index 0
    logic signed [31:0] list_q[$];
    t_resp resp_q[$];
    int n_fail = 0;
    int n_resp = 0;
    int cycles = 0;
    bit calm = 1'b0;
    int hits_n = 0, full_n = 0, empty_n = 0, miss_n = 0;

    function automatic int find_first(logic signed [31:0] k);
        foreach (list_q[i])
            if (list_q[i] == k) return i;
        return -1;
    endfunction

    function automatic t_resp predict_list(logic [3:0] req, logic signed [31:0] k,
                                           logic signed [31:0] v);
        t_resp r;
        int pos;
        r = '0;
        r.status = ST_OK;
        case (req)
            REQ_INS_FRONT, REQ_INS_BACK: begin
                if (list_q.size() >= CAP) r.status = ST_FULL;
                else if (req == REQ_INS_FRONT) list_q.push_front(v);
                else list_q.push_back(v);
            end
            REQ_INS_AFTER, REQ_INS_BEFORE: begin
                pos = find_first(k);
                if (list_q.size() >= CAP) r.status = ST_FULL;
                else if (pos < 0) r.status = ST_NOT_FOUND;
                else list_q.insert(req == REQ_INS_AFTER ? pos + 1 : pos, v);
            end
            REQ_DEL_FRONT, REQ_DEL_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK,
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (list_q.size() == 0) r.status = ST_EMPTY;
                else begin
                    if (req == REQ_DEL_FRONT || req == REQ_PEEK_FRONT
                            || req == REQ_POP_FRONT) begin
                        if (req != REQ_DEL_FRONT) r.read_data = list_q[0];
                        if (req != REQ_PEEK_FRONT) void'(list_q.pop_front());
                    end else begin
                        if (req != REQ_DEL_BACK) r.read_data = list_q[$];
                        if (req != REQ_PEEK_BACK) void'(list_q.pop_back());
                    end
                end
            end
            REQ_DEL_VALUE, REQ_FIND: begin
                pos = find_first(k);
                if (pos < 0) r.status = ST_NOT_FOUND;
                else if (req == REQ_FIND) r.found = 1'b1;
                else list_q.delete(pos);
            end
            default: ;
        endcase
        r.entry_count = 7'(list_q.size());
        r.empty_res = (list_q.size() == 0);
        case (r.status)
            ST_FULL: full_n++;
            ST_EMPTY: empty_n++;
            ST_NOT_FOUND: miss_n++;
            default: if (r.found) hits_n++;
        endcase
        return r;
    endfunction

    // result side: random stalls in bursts
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 12);
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_resp e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            n_resp <= n_resp + 1;
            if (resp_q.size() == 0) begin
                $error("result with no request outstanding");
                n_fail++;
            end else begin
                e = resp_q.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    n_fail++;
                end
                if (o_found !== e.found) begin
                    $error("found exp %0d got %0d", e.found, o_found);
                    n_fail++;
                end
                if (o_read_data !== e.read_data) begin
                    $error("read_data exp %0d got %0d", e.read_data, o_read_data);
                    n_fail++;
                end
                if (o_entry_count !== e.entry_count) begin
                    $error("entry_count exp %0d got %0d", e.entry_count, o_entry_count);
                    n_fail++;
                end
                if (o_empty_res !== e.empty_res) begin
                    $error("empty_res exp %0d got %0d", e.empty_res, o_empty_res);
                    n_fail++;
                end
            end
        end
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // one transfer on the request side; typed expectation checked if given
    task automatic send_req(logic [3:0] req, logic signed [31:0] k, logic signed [31:0] v,
                            bit typed = 1'b0, t_resp want = '0);
        t_resp p;
        int gap;
        // valid is already low here; the block is busy after taking a request anyway
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 1;
        repeat (gap) @(negedge i_clk);
        i_req_type <= req;
        i_key <= k;
        i_value <= v;
        i_valid <= 1'b1;
        p = predict_list(req, k, v);
        if (typed && p !== want) begin
            $error("directed row: predictor %h vs typed %h", p, want);
            n_fail++;
        end
        resp_q.push_back(typed ? want : p);
        do @(posedge i_clk); while (!(o_ready && i_valid));
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (resp_q.size() != 0) @(negedge i_clk);
        repeat (2 * CAP + 20) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_key();
        if (list_q.size() != 0 && $urandom_range(0, 3) != 0)
            return list_q[$urandom_range(0, list_q.size() - 1)];
        return pick_value();
    endfunction

    typedef struct {
        logic [3:0] req;
        logic signed [31:0] k;
        logic signed [31:0] v;
        bit typed;
        t_resp want;
    } t_row;

    t_row rows[] = '{
        '{REQ_PEEK_FRONT, 0, 0, 1, '{ST_EMPTY, 0, 0, 0, 1}},
        '{REQ_POP_BACK, 0, 0, 1, '{ST_EMPTY, 0, 0, 0, 1}},
        '{REQ_DEL_FRONT, 0, 0, 1, '{ST_EMPTY, 0, 0, 0, 1}},
        '{REQ_DEL_BACK, 0, 0, 1, '{ST_EMPTY, 0, 0, 0, 1}},
        '{REQ_FIND, 5, 0, 1, '{ST_NOT_FOUND, 0, 0, 0, 1}},
        '{REQ_INS_AFTER, 5, 1, 1, '{ST_NOT_FOUND, 0, 0, 0, 1}},
        '{REQ_DEL_VALUE, 5, 0, 1, '{ST_NOT_FOUND, 0, 0, 0, 1}},
        '{REQ_UNUSED, 0, 0, 1, '{ST_OK, 0, 0, 0, 1}},
        '{REQ_INS_BACK, 0, 32'sh7fffffff, 1, '{ST_OK, 0, 0, 1, 0}},
        '{REQ_PEEK_BACK, 0, 0, 1, '{ST_OK, 0, 32'sh7fffffff, 1, 0}},
        '{REQ_INS_FRONT, 0, 32'sh80000000, 0, '0},
        '{REQ_INS_AFTER, 32'sh80000000, -1, 0, '0},
        '{REQ_INS_BEFORE, 32'sh7fffffff, 7, 0, '0},
        '{REQ_INS_BEFORE, 32'sh80000000, 9, 0, '0},
        '{REQ_FIND, 7, 0, 0, '0},
        '{REQ_FIND, -1, 0, 0, '0},
        '{REQ_PEEK_FRONT, 0, 0, 0, '0},
        '{REQ_DEL_VALUE, 7, 0, 0, '0},
        '{REQ_POP_FRONT, 0, 0, 0, '0},
        '{REQ_POP_BACK, 0, 0, 0, '0},
        '{4'd15, 0, 0, 0, '0},
        '{REQ_DEL_BACK, 0, 0, 0, '0},
        '{REQ_DEL_FRONT, 0, 0, 0, '0}
    };

    initial begin
        int mode;
        logic [3:0] req;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i])
            send_req(rows[i].req, rows[i].k, rows[i].v, rows[i].typed, rows[i].want);

        // fill to capacity, probe the full case, then search, delete, refill and empty the list
        drain();
        while (list_q.size() < CAP) send_req(REQ_INS_BACK, 0, pick_value());
        send_req(REQ_INS_FRONT, 0, 1, 1'b1, '{ST_FULL, 0, 0, 7'(CAP), 0});
        send_req(REQ_INS_AFTER, list_q[0], 1, 1'b1, '{ST_FULL, 0, 0, 7'(CAP), 0});
        send_req(REQ_FIND, list_q[$], 0);
        send_req(REQ_DEL_VALUE, list_q[$], 0);
        send_req(REQ_INS_BEFORE, list_q[0], 3);
        while (list_q.size() > 0) send_req(REQ_POP_FRONT, 0, 0);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 100) calm = 1'b1;
            if (n == N_RANDOM / 2) drain();
            // drift between growing and shrinking phases
            mode = (n / 80) % 2;
            if ($urandom_range(0, 99) < (mode ? 30 : 65))
                req = 4'($urandom_range(0, 3));
            else
                req = 4'($urandom_range(4, 11));
            if ($urandom_range(0, 40) == 0) req = 4'($urandom_range(12, 15));
            send_req(req, pick_key(), pick_value());
        end

        drain();
        $display("%0d results: %0d finds hit, %0d misses, %0d empty, %0d full answers",
                 n_resp, hits_n, miss_n, empty_n, full_n);
        if (n_fail == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
